// ===== rtl/fptls_pkg.sv =====
// Shared types and constants for the FIFO page table with LOOK seek accounting.
package fptls_pkg;

    localparam int FRAMES  = 16;
    localparam int PAGES   = 64;
    localparam int TRACKS  = 1024;

    localparam int FRAME_W = $clog2(FRAMES);
    localparam int FILL_W  = $clog2(FRAMES + 1);
    localparam int PAGE_W  = $clog2(PAGES);
    localparam int NPAGE_W = $clog2(PAGES + 1);
    localparam int TRACK_W = $clog2(TRACKS);
    localparam int SEEK_W  = TRACK_W + 1;
    localparam int OFF_W   = 20;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 20;

    localparam logic [FILL_W-1:0]  FRAMES_IN_USE_RST = FILL_W'(16);
    localparam logic [NPAGE_W-1:0] VIRTUAL_PAGES_RST = NPAGE_W'(64);
    localparam logic [OFF_W-1:0]   OFFSET_LIMIT_RST  = OFF_W'(4095);
    localparam logic [TRACK_W-1:0] START_HEAD_RST    = '0;

    typedef enum logic [1:0] {
        CFG_FRAMES_IN_USE = 2'd0,
        CFG_VIRTUAL_PAGES = 2'd1,
        CFG_OFFSET_LIMIT  = 2'd2,
        CFG_START_HEAD    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        STATUS_HIT          = 3'd0,
        STATUS_FAULT_FREE   = 3'd1,
        STATUS_FAULT_EVICT  = 3'd2,
        STATUS_OFFSET_REJ   = 3'd3,
        STATUS_PAGE_RANGE   = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE    = 1'b0,
        ST_RESOLVE = 1'b1
    } state_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [OFF_W-1:0]   req_offset;
        logic [TRACK_W-1:0] page_track;
    } req_item_t;

    typedef struct packed {
        status_t            status;
        logic [FRAME_W-1:0] frame;
        logic [OFF_W-1:0]   offset_out;
        logic [PAGE_W-1:0]  evicted_page;
        logic [CNT_W-1:0]   fault_count;
        logic [CNT_W-1:0]   access_count;
        logic [SEEK_W-1:0]  travel;
    } res_item_t;

    typedef struct packed {
        cfg_index_t         index;
        logic [CFG_W-1:0]   value;
    } cfg_req_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/fptls_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
interface fptls_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fptls_ctrl.sv =====
// Controller state machine: sequences capture and commit of one request.
module fptls_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  fptls_pkg::dp_stat_t  stat,
    output fptls_pkg::ctrl_cmd_t cmd
);
    import fptls_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                // hold until the result register can take the answer
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/fptls_dp.sv =====
// Datapath: page tables, FIFO pointer, counters, seek range and result register.
module fptls_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fptls_pkg::req_item_t  req_data,
    input  fptls_pkg::ctrl_cmd_t  cmd,
    output fptls_pkg::dp_stat_t   stat,
    fptls_stream_if.source        result,
    fptls_stream_if.sink          cfg
);
    import fptls_pkg::*;

    // configuration
    logic [FILL_W-1:0]  frames_in_use_reg;
    logic [NPAGE_W-1:0] virtual_pages_reg;
    logic [OFF_W-1:0]   offset_limit_reg;
    logic [TRACK_W-1:0] start_head_reg;

    // captured request
    logic [PAGE_W-1:0]  page_reg;
    logic [OFF_W-1:0]   req_offset_reg;
    logic [TRACK_W-1:0] track_reg;

    // tables
    logic [FRAME_W-1:0] page_map_mem [PAGES];
    logic [PAGE_W-1:0]  owner_mem [FRAMES];
    logic [FRAME_W-1:0] map_rd_reg;
    logic [PAGE_W-1:0]  owner_rd_reg;
    logic [PAGES-1:0]   page_valid_reg;

    logic [FILL_W-1:0]  frames_filled_reg;
    logic [FRAME_W-1:0] fifo_ptr_reg;
    logic [CNT_W-1:0]   faults_reg;
    logic [CNT_W-1:0]   accesses_reg;
    logic [TRACK_W-1:0] low_reg;
    logic [TRACK_W-1:0] high_reg;
    logic               any_reg;

    logic               out_valid_reg;
    res_item_t          out_data_reg;

    logic [FILL_W-1:0]  nframes;
    logic [NPAGE_W-1:0] npages;
    logic [FRAME_W-1:0] ptr_wrap;
    logic [FILL_W-1:0]  ptr_inc;
    logic [FRAME_W-1:0] ptr_adv;
    logic               off_bad;
    logic               page_bad;
    logic               hit;
    logic               has_free;
    logic               access_ok;
    logic               fault;
    logic [FRAME_W-1:0] victim_frame;
    logic [PAGES-1:0]   page_valid_next;
    logic [CNT_W-1:0]   faults_next;
    logic [CNT_W-1:0]   accesses_next;
    logic [TRACK_W-1:0] low_next;
    logic [TRACK_W-1:0] high_next;
    logic               any_next;
    logic [TRACK_W-1:0] seek_left;
    logic [TRACK_W-1:0] sweep_start;
    logic [TRACK_W-1:0] seek_right;
    logic [SEEK_W-1:0]  seek_sum;
    res_item_t          res_next;

    assign cfg.ready     = 1'b1;
    assign stat.out_free = !out_valid_reg || result.ready;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_IN_USE_RST;
            virtual_pages_reg <= VIRTUAL_PAGES_RST;
            offset_limit_reg  <= OFFSET_LIMIT_RST;
            start_head_reg    <= START_HEAD_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                CFG_FRAMES_IN_USE: frames_in_use_reg <= cfg.data.value[FILL_W-1:0];
                CFG_VIRTUAL_PAGES: virtual_pages_reg <= cfg.data.value[NPAGE_W-1:0];
                CFG_OFFSET_LIMIT:  offset_limit_reg  <= cfg.data.value[OFF_W-1:0];
                CFG_START_HEAD:    start_head_reg    <= cfg.data.value[TRACK_W-1:0];
            endcase
        end
    end

    // clamp the counts to their usable ranges
    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            nframes = FILL_W'(1);
        end
        else if (frames_in_use_reg > FILL_W'(FRAMES))
        begin
            nframes = FILL_W'(FRAMES);
        end
        else
        begin
            nframes = frames_in_use_reg;
        end

        if (virtual_pages_reg == '0)
        begin
            npages = NPAGE_W'(1);
        end
        else if (virtual_pages_reg > NPAGE_W'(PAGES))
        begin
            npages = NPAGE_W'(PAGES);
        end
        else
        begin
            npages = virtual_pages_reg;
        end
    end

    // a pointer left beyond a lowered frame count restarts at frame zero
    assign ptr_wrap = ({1'b0, fifo_ptr_reg} >= nframes) ? '0 : fifo_ptr_reg;
    assign ptr_inc  = {1'b0, ptr_wrap} + FILL_W'(1);
    assign ptr_adv  = (ptr_inc == nframes) ? '0 : ptr_inc[FRAME_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg       <= req_data.page;
            req_offset_reg <= req_data.req_offset;
            track_reg      <= req_data.page_track;
            map_rd_reg     <= page_map_mem[req_data.page];
            owner_rd_reg   <= owner_mem[ptr_wrap];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && fault)
        begin
            page_map_mem[page_reg]  <= victim_frame;
            owner_mem[victim_frame] <= page_reg;
        end
    end

    always_comb
    begin
        off_bad      = req_offset_reg > offset_limit_reg;
        page_bad     = {1'b0, page_reg} >= npages;
        hit          = page_valid_reg[page_reg];
        has_free     = frames_filled_reg < nframes;
        access_ok    = !off_bad && !page_bad;
        fault        = access_ok && !hit;
        victim_frame = has_free ? frames_filled_reg[FRAME_W-1:0] : ptr_wrap;

        page_valid_next = page_valid_reg;
        if (fault)
        begin
            // drop the evicted owner before mapping the new page
            if (!has_free)
            begin
                page_valid_next[owner_rd_reg] = 1'b0;
            end
            page_valid_next[page_reg] = 1'b1;
        end

        faults_next   = faults_reg;
        accesses_next = accesses_reg;
        if (access_ok && accesses_reg != '1)
        begin
            accesses_next = accesses_reg + CNT_W'(1);
        end
        if (fault && faults_reg != '1)
        begin
            faults_next = faults_reg + CNT_W'(1);
        end

        low_next  = low_reg;
        high_next = high_reg;
        any_next  = any_reg;
        if (fault)
        begin
            if (!any_reg || track_reg < low_reg)
            begin
                low_next = track_reg;
            end
            if (!any_reg || track_reg > high_reg)
            begin
                high_next = track_reg;
            end
            any_next = 1'b1;
        end

        // LOOK: sweep left to the lowest track, then right to the highest
        seek_left   = '0;
        sweep_start = start_head_reg;
        seek_right  = '0;
        if (low_next <= start_head_reg)
        begin
            seek_left   = start_head_reg - low_next;
            sweep_start = low_next;
        end
        if (high_next > start_head_reg)
        begin
            seek_right = high_next - sweep_start;
        end
        seek_sum = any_next ? ({1'b0, seek_left} + {1'b0, seek_right}) : '0;

        res_next.status       = STATUS_HIT;
        res_next.frame        = '0;
        res_next.offset_out   = '0;
        res_next.evicted_page = '0;
        res_next.fault_count  = faults_next;
        res_next.access_count = accesses_next;
        res_next.travel       = seek_sum;
        priority if (off_bad)
        begin
            res_next.status = STATUS_OFFSET_REJ;
        end
        else if (page_bad)
        begin
            res_next.status = STATUS_PAGE_RANGE;
        end
        else if (hit)
        begin
            res_next.status     = STATUS_HIT;
            res_next.frame      = map_rd_reg;
            res_next.offset_out = req_offset_reg;
        end
        else if (has_free)
        begin
            res_next.status     = STATUS_FAULT_FREE;
            res_next.frame      = victim_frame;
            res_next.offset_out = req_offset_reg;
        end
        else
        begin
            res_next.status       = STATUS_FAULT_EVICT;
            res_next.frame        = victim_frame;
            res_next.offset_out   = req_offset_reg;
            res_next.evicted_page = owner_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_valid_reg    <= '0;
            frames_filled_reg <= '0;
            fifo_ptr_reg      <= '0;
            faults_reg        <= '0;
            accesses_reg      <= '0;
            low_reg           <= '1;
            high_reg          <= '0;
            any_reg           <= 1'b0;
        end
        else if (cmd.commit)
        begin
            faults_reg     <= faults_next;
            accesses_reg   <= accesses_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            any_reg        <= any_next;
            page_valid_reg <= page_valid_next;
            if (fault)
            begin
                if (has_free)
                begin
                    frames_filled_reg <= frames_filled_reg + FILL_W'(1);
                end
                else
                begin
                    fifo_ptr_reg <= ptr_adv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= res_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frames_filled_reg <= FILL_W'(FRAMES))
        else $error("frame fill count beyond frame store");

    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || result.ready))
        else $error("result committed over an untaken result");

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !fault) |=> $stable(faults_reg))
        else $error("fault count moved without a fault");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result.valid)
        else $error("committed result not presented");

endmodule

// ===== rtl/fifo_page_table_with_look_seek_top.sv =====
// A request is captured together with its page-table and owner reads, then committed
// to the result register, which presents the result; tables and counters update at commit.
// No new request is accepted until the last one is committed, so requests do not overlap.
// A request taken while the result register is full holds until that result leaves.
// Reset clears page-valid flags, fill count, pointer, counters and seek range at once.
module fifo_page_table_with_look_seek_top (
    input  logic           clk,
    input  logic           rst_n,
    fptls_stream_if.sink   request,
    fptls_stream_if.source result,
    fptls_stream_if.sink   cfg
);
    import fptls_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    fptls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fptls_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (request.data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result),
        .cfg      (cfg)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the FIFO page table with LOOK seek accounting.
module tb_top;
    import fptls_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;

    fptls_stream_if #(.T(req_item_t)) request_ch ();
    fptls_stream_if #(.T(res_item_t)) result_ch ();
    fptls_stream_if #(.T(cfg_req_t))  cfg_ch ();

    fifo_page_table_with_look_seek_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch),
        .cfg     (cfg_ch)
    );

    // Shadow of the block's tables, counters and registers
    bit                 page_valid [PAGES];
    logic [FRAME_W-1:0] page_frame [PAGES];
    logic [PAGE_W-1:0]  frame_page [FRAMES];
    int unsigned        filled_frames;
    int unsigned        fifo_next;
    logic [CNT_W-1:0]   fault_total;
    logic [CNT_W-1:0]   access_total;
    int unsigned        track_lo;
    int unsigned        track_hi;
    bit                 track_seen;
    int unsigned        cur_frames;
    int unsigned        cur_pages;
    int unsigned        cur_limit;
    int unsigned        cur_head;

    res_item_t expected_q [$];

    int send_idle_pct;
    int stall_pct;
    int hold_left;
    int quiet_cycles;
    int fail_count;
    int n_requests;
    int n_results;
    int n_writes;
    int n_settings;
    int status_seen [5];

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void apply_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        case (idx)
            CFG_FRAMES_IN_USE: cur_frames = value[4:0];
            CFG_VIRTUAL_PAGES: cur_pages  = value[6:0];
            CFG_OFFSET_LIMIT:  cur_limit  = value[19:0];
            CFG_START_HEAD:    cur_head   = value[9:0];
            default: ;
        endcase
    endfunction

    function automatic int unsigned frames_now();
        if (cur_frames < 1)
            return 1;
        if (cur_frames > FRAMES)
            return FRAMES;
        return cur_frames;
    endfunction

    function automatic int unsigned pages_now();
        if (cur_pages < 1)
            return 1;
        if (cur_pages > PAGES)
            return PAGES;
        return cur_pages;
    endfunction

    function automatic res_item_t predict_access(req_item_t acc);
        res_item_t   r;
        int unsigned nfr;
        int unsigned trk;
        int unsigned victim;
        int unsigned span;
        int unsigned sweep;
        int unsigned head;
        nfr  = frames_now();
        trk  = acc.page_track;
        head = cur_head;
        if (trk > TRACKS - 1)
            trk = TRACKS - 1;
        if (head > TRACKS - 1)
            head = TRACKS - 1;
        r = '0;
        if (acc.req_offset > cur_limit)
            r.status = STATUS_OFFSET_REJ;
        else if (acc.page >= pages_now())
            r.status = STATUS_PAGE_RANGE;
        else
        begin
            r.offset_out = acc.req_offset;
            if (access_total != '1)
                access_total++;
            if (page_valid[acc.page])
            begin
                r.status = STATUS_HIT;
                r.frame  = page_frame[acc.page];
            end
            else
            begin
                if (!track_seen || trk < track_lo)
                    track_lo = trk;
                if (!track_seen || trk > track_hi)
                    track_hi = trk;
                track_seen = 1'b1;
                if (filled_frames < nfr)
                begin
                    r.status = STATUS_FAULT_FREE;
                    r.frame  = FRAME_W'(filled_frames);
                    filled_frames++;
                end
                else
                begin
                    r.status = STATUS_FAULT_EVICT;
                    // wrap a pointer left beyond a lowered frame count
                    if (fifo_next >= nfr)
                        fifo_next = 0;
                    r.frame = FRAME_W'(fifo_next);
                    victim  = frame_page[fifo_next];
                    r.evicted_page = PAGE_W'(victim);
                    if (victim < PAGES)
                        page_valid[victim] = 1'b0;
                    fifo_next = (fifo_next + 1) % nfr;
                end
                frame_page[r.frame]  = acc.page;
                page_frame[acc.page] = r.frame;
                page_valid[acc.page] = 1'b1;
                if (fault_total != '1)
                    fault_total++;
            end
        end
        r.fault_count  = fault_total;
        r.access_count = access_total;
        span = 0;
        if (track_seen)
        begin
            sweep = head;
            if (track_lo <= head)
            begin
                span  = head - track_lo;
                sweep = track_lo;
            end
            if (track_hi > head)
                span += track_hi - sweep;
        end
        r.travel = span[SEEK_W-1:0];
        return r;
    endfunction

    function automatic void report_mismatch(int idx, res_item_t want, res_item_t got);
        $display("result %0d mismatch:", idx);
        $display("  expected st=%0d fr=%0d off=%0h ev=%0d flt=%0d acc=%0d seek=%0d",
                 want.status, want.frame, want.offset_out, want.evicted_page,
                 want.fault_count, want.access_count, want.travel);
        $display("  got      st=%0d fr=%0d off=%0h ev=%0d flt=%0d acc=%0d seek=%0d",
                 got.status, got.frame, got.offset_out, got.evicted_page,
                 got.fault_count, got.access_count, got.travel);
    endfunction

    // Check results, track register writes and predict each accepted request
    always @(posedge clk)
    begin
        res_item_t want;
        res_item_t got;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                n_results++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: st=%0d fr=%0d off=%0h", got.status,
                                 got.frame, got.offset_out);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.frame !== want.frame ||
                        got.offset_out !== want.offset_out ||
                        got.evicted_page !== want.evicted_page ||
                        got.fault_count !== want.fault_count ||
                        got.access_count !== want.access_count ||
                        got.travel !== want.travel)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            report_mismatch(n_results, want, got);
                    end
                    if (want.status <= STATUS_PAGE_RANGE)
                        status_seen[want.status]++;
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                apply_reg(cfg_ch.data.index, cfg_ch.data.value);
                n_writes++;
            end
            if (request_ch.valid && request_ch.ready)
            begin
                expected_q.push_back(predict_access(request_ch.data));
                n_requests++;
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (request_ch.valid && request_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_access(input logic [PAGE_W-1:0] pg, input logic [OFF_W-1:0] off,
                               input logic [TRACK_W-1:0] trk);
        req_item_t acc;
        acc.page       = pg;
        acc.req_offset = off;
        acc.page_track = trk;
        if ($urandom_range(99) < send_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        request_ch.valid <= 1'b1;
        request_ch.data  <= acc;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_access();
        int unsigned nfr;
        int unsigned npg;
        int unsigned top;
        int unsigned pg;
        int unsigned off;
        nfr = frames_now();
        npg = pages_now();
        top = 2 * nfr + 1;
        if (top > npg - 1)
            top = npg - 1;
        // keep most requests inside a small working set so hits and evictions mix
        if ($urandom_range(99) < 85)
            pg = $urandom_range(0, top);
        else
            pg = $urandom_range(0, PAGES - 1);
        if ($urandom_range(99) < 85)
            off = $urandom_range(0, cur_limit);
        else
            off = $urandom_range(0, 20'hFFFFF);
        send_access(PAGE_W'(pg), OFF_W'(off), TRACK_W'($urandom_range(0, TRACKS - 1)));
    endtask

    task automatic drain();
        request_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    // Write all four registers once the block is idle; unused upper bits get noise
    task automatic configure(input int unsigned fr, input int unsigned pg,
                             input int unsigned lim, input int unsigned hd);
        logic [CFG_W-1:0] vals [4];
        cfg_req_t         wr;
        drain();
        vals[0] = (CFG_W'($urandom) & ~CFG_W'('h1F))  | CFG_W'(fr & 'h1F);
        vals[1] = (CFG_W'($urandom) & ~CFG_W'('h7F))  | CFG_W'(pg & 'h7F);
        vals[2] = CFG_W'(lim);
        vals[3] = (CFG_W'($urandom) & ~CFG_W'('h3FF)) | CFG_W'(hd & 'h3FF);
        for (int i = 0; i < 4; i++)
        begin
            wr.index = cfg_index_t'(i);
            wr.value = vals[i];
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= wr;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic test_reset_values();
        send_idle_pct = 30;
        stall_pct     = 30;
        send_access(0, 0, 1023);
        send_access(0, 4095, 0);
        send_access(1, 4096, 5);
        // an offset beyond the limit is rejected; page 63 is still in range
        send_access(63, 20'hFFFFF, 5);
        send_access(63, 7, 0);
        send_access(5, 0, 512);
    endtask

    task automatic test_register_edges();
        configure(2, 4, 20'hFFFFF, 512);
        send_access(4, 0, 0);
        send_access(63, 1, 1);
        send_access(5, 9, 9);
        send_access(0, 20'hFFFFF, 3);
        send_access(1, 2, 700);
        send_access(2, 3, 100);
        send_access(3, 4, 1023);
        // zero counts clamp to one; FIFO pointer wraps
        configure(0, 0, 0, 1023);
        send_access(0, 1, 0);
        send_access(0, 0, 0);
        send_access(0, 0, 0);
        send_access(1, 0, 0);
        configure(31, 127, 20'hFFFFF, 0);
        send_access(40, 0, 1023);
        send_access(5, 0, 0);
        // pages in frames above the new count still hit
        configure(1, 64, 4095, 0);
        send_access(40, 0, 0);
        send_access(41, 0, 0);
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int n,
                                       input int unsigned fr, input int unsigned pg,
                                       input int unsigned lim, input int unsigned hd);
        configure(fr, pg, lim, hd);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n)
            send_random_access();
    endtask

    task automatic test_backpressure();
        configure(4, 16, 4095, 100);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 300;
        repeat (50)
            send_random_access();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        request_ch.valid = 1'b0;
        request_ch.data  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        result_ch.ready  = 1'b0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        hold_left        = 0;
        quiet_cycles     = 0;
        fail_count       = 0;
        n_requests       = 0;
        n_results        = 0;
        n_writes         = 0;
        n_settings       = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (page_valid[i])
        begin
            page_valid[i] = 1'b0;
            page_frame[i] = '0;
        end
        foreach (frame_page[i])
            frame_page[i] = '0;
        filled_frames = 0;
        fifo_next     = 0;
        fault_total   = '0;
        access_total  = '0;
        track_lo      = TRACKS - 1;
        track_hi      = 0;
        track_seen    = 1'b0;
        cur_frames    = FRAMES_IN_USE_RST;
        cur_pages     = VIRTUAL_PAGES_RST;
        cur_limit     = OFFSET_LIMIT_RST;
        cur_head      = START_HEAD_RST;

        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_register_edges();
        test_random_traffic(0, 0, 160, 16, 64, 20'hFFFFF, 1023);
        test_random_traffic(65, 0, 160, 1, 64, 20'hFFFFF, 0);
        test_backpressure();
        test_random_traffic(0, 65, 160, $urandom_range(2, 8), $urandom_range(1, 127),
                            $urandom_range(1000, 20'hFFFFF), $urandom_range(0, TRACKS - 1));
        test_random_traffic(30, 30, 160, $urandom_range(0, 31), $urandom_range(0, 127),
                            $urandom_range(0, 20'hFFFFF), $urandom_range(0, TRACKS - 1));

        drain();
        // hold a little longer to catch any stray result
        repeat (8)
            @(negedge clk);

        $display(
            "covered %0d requests: %0d hits, %0d fills, %0d evictions, %0d bad offsets, %0d bad pages",
            n_requests, status_seen[STATUS_HIT], status_seen[STATUS_FAULT_FREE],
            status_seen[STATUS_FAULT_EVICT], status_seen[STATUS_OFFSET_REJ],
            status_seen[STATUS_PAGE_RANGE]);
        $display("%0d register writes over %0d settings, %0d results checked, %0d failures",
                 n_writes, n_settings, n_results, fail_count);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fptls_pkg.sv
rtl/fptls_stream_if.sv
rtl/fptls_ctrl.sv
rtl/fptls_dp.sv
rtl/fifo_page_table_with_look_seek_top.sv
dv/tb_top.sv
